FILE: sv/rmfw_pkg.sv
package rmfw_pkg;

  // Width of a thread identifier
  localparam int ID_W = 8;

  // Result status codes
  typedef enum logic [3:0] {
    ST_GRANTED    = 4'd0,
    ST_RECURSIVE  = 4'd1,
    ST_QUEUED     = 4'd2,
    ST_LOWERED    = 4'd3,
    ST_FREED      = 4'd4,
    ST_HANDED     = 4'd5,
    ST_NOT_HOLDER = 4'd6,
    ST_DUP_WAIT   = 4'd7,
    ST_FULL       = 4'd8,
    ST_SATURATED  = 4'd9
  } status_t;

  // Request kinds
  typedef enum logic {
    MODE_ACQUIRE = 1'b0,
    MODE_RELEASE = 1'b1
  } mode_t;

  // Controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } ctrl_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;   // capture request, read queue head
    logic exec;   // decide and update lock state
  } cmd_t;

endpackage

FILE: sv/rmfw_ctrl.sv
module rmfw_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  output rmfw_pkg::cmd_t      cmd
);

  rmfw_pkg::ctrl_state_t state;
  rmfw_pkg::ctrl_state_t state_next;

  // Hold state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rmfw_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance: capture on start in idle, then execute, then back to idle
  always_comb begin
    state_next = state;
    case (state)
      rmfw_pkg::S_IDLE: begin
        if (start) state_next = rmfw_pkg::S_EXEC;
      end
      rmfw_pkg::S_EXEC: begin
        state_next = rmfw_pkg::S_IDLE;
      end
      default: begin
        state_next = rmfw_pkg::S_IDLE;
      end
    endcase
  end

  // Drive commands
  always_comb begin
    cmd.load = 1'b0;
    cmd.exec = 1'b0;
    busy     = 1'b0;
    case (state)
      rmfw_pkg::S_IDLE: begin
        cmd.load = start;
      end
      rmfw_pkg::S_EXEC: begin
        cmd.exec = 1'b1;
        busy     = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  // Execute lasts exactly one cycle and follows a load
  assert property (@(posedge clk) disable iff (rst) cmd.exec |=> !cmd.exec)
    else $error("execute cycle repeated");
  assert property (@(posedge clk) disable iff (rst) cmd.load |=> cmd.exec)
    else $error("load not followed by execute");
  assert property (@(posedge clk) disable iff (rst) !(cmd.load && cmd.exec))
    else $error("load during execute");

endmodule

FILE: sv/rmfw_dp.sv
module rmfw_dp #(
  parameter int MAX_THREADS   = 256,
  parameter int MAX_WAITERS   = 16,
  parameter int MAX_RECURSION = 255
) (
  input  logic                       clk,
  input  logic                       rst,
  input  rmfw_pkg::cmd_t             cmd,
  input  logic                       mode,
  input  logic [rmfw_pkg::ID_W-1:0]  thread_id,
  output logic                       done,
  output logic [3:0]                 status,
  output logic                       woken_valid,
  output logic [rmfw_pkg::ID_W-1:0]  woken_thread,
  output logic                       lock_held,
  output logic [7:0]                 hold_count
);

  localparam int IDN    = 1 << rmfw_pkg::ID_W;
  localparam int MARK_N = (MAX_THREADS < IDN) ? MAX_THREADS : IDN;
  localparam int MW     = (MARK_N > 1) ? $clog2(MARK_N) : 1;
  localparam int HW     = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
  localparam int CNW    = $clog2(MAX_WAITERS + 1);
  localparam int CW     = $clog2(MAX_RECURSION + 1);

  localparam logic [HW:0]   WAIT_N    = (HW+1)'(MAX_WAITERS);
  localparam logic [HW-1:0] HEAD_LAST = HW'(MAX_WAITERS - 1);
  localparam logic [CNW-1:0] CNT_FULL = CNW'(MAX_WAITERS);
  localparam logic [CW-1:0] REC_MAX   = CW'(MAX_RECURSION);

  // Request capture
  logic                      mode_q;
  logic [rmfw_pkg::ID_W-1:0] tid_q;

  // Lock state
  logic                      owner_valid;
  logic [rmfw_pkg::ID_W-1:0] owner_id;
  logic [CW-1:0]             rec;
  logic [HW-1:0]             head;
  logic [CNW-1:0]            fcount;
  logic [MARK_N-1:0]         marks;

  // Waiter queue memory
  logic [rmfw_pkg::ID_W-1:0] wq [MAX_WAITERS];
  logic [rmfw_pkg::ID_W-1:0] rd_data;

  // Next values
  logic                      owner_valid_next;
  logic [rmfw_pkg::ID_W-1:0] owner_id_next;
  logic [CW-1:0]             rec_next;
  logic [HW-1:0]             head_next;
  logic [CNW-1:0]            fcount_next;
  logic                      set_mark;
  logic                      clr_mark;
  logic                      wr_en;
  logic                      wake;
  rmfw_pkg::status_t         st;

  logic                      owner_match;
  logic                      mark_hit;
  logic [MW-1:0]             req_mark;
  logic [MW-1:0]             next_mark;
  logic [HW:0]               tail_sum;
  logic [HW-1:0]             tail;
  logic [CW+7:0]             rec_wide;

  // Thread id to waiting mark index, built at elaboration
  logic [MW-1:0] mark_lut [IDN];
  for (genvar g = 0; g < IDN; g++) begin : g_lut
    assign mark_lut[g] = MW'(g % MAX_THREADS);
  end

  assign req_mark    = mark_lut[tid_q];
  assign next_mark   = mark_lut[rd_data];
  assign mark_hit    = marks[req_mark];
  assign owner_match = owner_valid && (owner_id == tid_q);

  // Tail slot: head plus count, wrapped once
  assign tail_sum = {1'b0, head} + (HW+1)'(fcount);
  always_comb begin
    logic [HW:0] wrapped;
    wrapped = tail_sum - WAIT_N;
    tail = (tail_sum >= WAIT_N) ? wrapped[HW-1:0] : tail_sum[HW-1:0];
  end

  // Decide the outcome of one request
  always_comb begin
    owner_valid_next = owner_valid;
    owner_id_next    = owner_id;
    rec_next         = rec;
    head_next        = head;
    fcount_next      = fcount;
    set_mark         = 1'b0;
    clr_mark         = 1'b0;
    wr_en            = 1'b0;
    wake             = 1'b0;
    st               = rmfw_pkg::ST_GRANTED;
    if (mode_q == rmfw_pkg::MODE_ACQUIRE) begin
      if (owner_match) begin
        if (rec >= REC_MAX) begin
          st = rmfw_pkg::ST_SATURATED;
        end else begin
          rec_next = rec + 1'b1;
          st       = rmfw_pkg::ST_RECURSIVE;
        end
      end else if (!owner_valid) begin
        owner_valid_next = 1'b1;
        owner_id_next    = tid_q;
        rec_next         = CW'(1);
        st               = rmfw_pkg::ST_GRANTED;
      end else if (mark_hit) begin
        st = rmfw_pkg::ST_DUP_WAIT;
      end else if (fcount >= CNT_FULL) begin
        st = rmfw_pkg::ST_FULL;
      end else begin
        wr_en       = 1'b1;
        set_mark    = 1'b1;
        fcount_next = fcount + 1'b1;
        st          = rmfw_pkg::ST_QUEUED;
      end
    end else begin
      if (!owner_match) begin
        st = rmfw_pkg::ST_NOT_HOLDER;
      end else if (rec > CW'(1)) begin
        rec_next = rec - 1'b1;
        st       = rmfw_pkg::ST_LOWERED;
      end else if (fcount != '0) begin
        head_next     = (head == HEAD_LAST) ? '0 : head + 1'b1;
        fcount_next   = fcount - 1'b1;
        clr_mark      = 1'b1;
        owner_id_next = rd_data;
        rec_next      = CW'(1);
        wake          = 1'b1;
        st            = rmfw_pkg::ST_HANDED;
      end else begin
        owner_valid_next = 1'b0;
        owner_id_next    = '0;
        rec_next         = '0;
        st               = rmfw_pkg::ST_FREED;
      end
    end
  end

  assign rec_wide = {8'b0, rec_next};

  // Capture the request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q <= mode;
      tid_q  <= thread_id;
    end
  end

  // Queue memory: write tail on enqueue, read head on load
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) wq[tail] <= tid_q;
    if (cmd.load) rd_data <= wq[head];
  end

  // Update lock state and waiting marks
  always_ff @(posedge clk) begin
    if (rst) begin
      owner_valid <= 1'b0;
      owner_id    <= '0;
      rec         <= '0;
      head        <= '0;
      fcount      <= '0;
      marks       <= '0;
    end else if (cmd.exec) begin
      owner_valid <= owner_valid_next;
      owner_id    <= owner_id_next;
      rec         <= rec_next;
      head        <= head_next;
      fcount      <= fcount_next;
      if (set_mark) marks[req_mark]  <= 1'b1;
      if (clr_mark) marks[next_mark] <= 1'b0;
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.exec;
    end
  end

  // Result beat payload
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status       <= st;
      woken_valid  <= wake;
      woken_thread <= wake ? rd_data : '0;
      lock_held    <= owner_valid_next;
      hold_count   <= owner_valid_next ? rec_wide[7:0] : 8'd0;
    end
  end

  assert property (@(posedge clk) disable iff (rst) cmd.exec |=> done)
    else $error("result beat missing after execute");
  assert property (@(posedge clk) disable iff (rst) !cmd.exec |=> !done)
    else $error("result beat without execute");
  assert property (@(posedge clk) disable iff (rst)
    done && woken_valid |-> status == rmfw_pkg::ST_HANDED && lock_held)
    else $error("wake without hand-over");
  assert property (@(posedge clk) disable iff (rst)
    done && !lock_held |-> hold_count == 8'd0)
    else $error("count shown on free lock");
  assert property (@(posedge clk) disable iff (rst) fcount <= CNT_FULL)
    else $error("waiter count overflow");
  assert property (@(posedge clk) disable iff (rst) fcount != '0 |-> owner_valid)
    else $error("waiters on free lock");

endmodule

FILE: sv/recursive_mutex_fifo_waiters.sv
// Recursive lock with a FIFO of waiting threads.
// Request channel: drive mode (0 acquire, 1 release) and thread_id with start
// high; the request is taken on a clock edge where start is high and busy low.
// Result channel: one result beat per request, shown for exactly one cycle
// with done high: status, woken_valid/woken_thread (thread handed the lock on
// release), lock_held and hold_count after the request.
// Steps: the accepting edge captures the request and reads the head of the
// waiter queue memory; the execute cycle then decides and updates owner,
// count, queue pointers and the waiting bit of the thread, and done is
// registered from it. A new request is not taken until the execute cycle
// is over.
// busy is high during the execute cycle only; a request may be presented in
// the same cycle as the previous result beat.
// Reset (rst, synchronous): lock free, queue empty, no thread marked waiting;
// no results pending. Queue entries need no clearing.
// The receiver cannot stall: each result must be taken in its done cycle.
module recursive_mutex_fifo_waiters #(
  parameter int MAX_THREADS   = 256,
  parameter int MAX_WAITERS   = 16,
  parameter int MAX_RECURSION = 255
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       mode,
  input  logic [rmfw_pkg::ID_W-1:0]  thread_id,
  output logic                       done,
  output logic [3:0]                 status,
  output logic                       woken_valid,
  output logic [rmfw_pkg::ID_W-1:0]  woken_thread,
  output logic                       lock_held,
  output logic [7:0]                 hold_count
);

  rmfw_pkg::cmd_t cmd;

  // Sequence each request
  rmfw_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Lock state, waiter queue and result registers
  rmfw_dp #(
    .MAX_THREADS   (MAX_THREADS),
    .MAX_WAITERS   (MAX_WAITERS),
    .MAX_RECURSION (MAX_RECURSION)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .mode         (mode),
    .thread_id    (thread_id),
    .done         (done),
    .status       (status),
    .woken_valid  (woken_valid),
    .woken_thread (woken_thread),
    .lock_held    (lock_held),
    .hold_count   (hold_count)
  );

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int ID_W          = rmfw_pkg::ID_W;
  localparam int MAX_THREADS   = 256;
  localparam int MAX_WAITERS   = 16;
  localparam int MAX_RECURSION = 255;
  localparam int CYCLE_LIMIT   = 100000;
  localparam int RANDOM_ITEMS  = 1200;
  localparam int CROWD_SIZE    = 20;

  // Lock, waiter queue and waiting marks as the block should hold them
  typedef struct packed {
    logic                              held;
    logic [ID_W-1:0]                   owner;
    logic [7:0]                        depth;
    logic [MAX_WAITERS-1:0][ID_W-1:0]  waiters;
    logic [3:0]                        head;
    logic [4:0]                        nwait;
    logic [MAX_THREADS-1:0]            marks;
  } lock_state_t;

  typedef struct packed {
    rmfw_pkg::status_t status;
    logic              woken_valid;
    logic [ID_W-1:0]   woken_thread;
    logic              lock_held;
    logic [7:0]        hold_count;
  } lock_result_t;

  typedef struct packed {
    rmfw_pkg::mode_t mode;
    logic [ID_W-1:0] tid;
  } request_t;

  logic            clk;
  logic            rst = 1'b1;
  logic            start = 1'b0;
  logic            mode = 1'b0;
  logic [ID_W-1:0] thread_id = '0;
  logic            busy;
  logic            done;
  logic [3:0]      status;
  logic            woken_valid;
  logic [ID_W-1:0] woken_thread;
  logic            lock_held;
  logic [7:0]      hold_count;

  request_t     requests[$];
  lock_result_t results_due[$];
  lock_state_t  plan;
  lock_state_t  lock_now;
  lock_result_t want;
  logic         beat_taken = 1'b0;
  int           errors = 0;
  int           issued = 0;
  int           cycles = 0;

  recursive_mutex_fifo_waiters #(
    .MAX_THREADS  (MAX_THREADS),
    .MAX_WAITERS  (MAX_WAITERS),
    .MAX_RECURSION(MAX_RECURSION)
  ) uut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .mode        (mode),
    .thread_id   (thread_id),
    .done        (done),
    .status      (status),
    .woken_valid (woken_valid),
    .woken_thread(woken_thread),
    .lock_held   (lock_held),
    .hold_count  (hold_count)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Advance the lock state by one request and return the result it gives
  function automatic lock_result_t apply_request(inout lock_state_t s,
                                                 input rmfw_pkg::mode_t m,
                                                 input logic [ID_W-1:0] tid);
    lock_result_t    r;
    logic [ID_W-1:0] next;
    logic [3:0]      slot;
    r = '0;
    if (m == rmfw_pkg::MODE_ACQUIRE) begin
      if (s.held && s.owner == tid) begin
        if (s.depth >= MAX_RECURSION) begin
          r.status = rmfw_pkg::ST_SATURATED;
        end else begin
          s.depth = s.depth + 8'd1;
          r.status = rmfw_pkg::ST_RECURSIVE;
        end
      end else if (!s.held) begin
        s.held = 1'b1;
        s.owner = tid;
        s.depth = 8'd1;
        r.status = rmfw_pkg::ST_GRANTED;
      end else if (s.marks[tid]) begin
        r.status = rmfw_pkg::ST_DUP_WAIT;
      end else if (s.nwait >= MAX_WAITERS) begin
        r.status = rmfw_pkg::ST_FULL;
      end else begin
        // append at the tail, which wraps with the 4-bit index
        slot = s.head + s.nwait[3:0];
        s.waiters[slot] = tid;
        s.nwait = s.nwait + 5'd1;
        s.marks[tid] = 1'b1;
        r.status = rmfw_pkg::ST_QUEUED;
      end
    end else begin
      if (!s.held || s.owner != tid) begin
        r.status = rmfw_pkg::ST_NOT_HOLDER;
      end else if (s.depth > 8'd1) begin
        s.depth = s.depth - 8'd1;
        r.status = rmfw_pkg::ST_LOWERED;
      end else if (s.nwait != 0) begin
        // pass the lock straight to the head waiter
        next = s.waiters[s.head];
        s.head = s.head + 4'd1;
        s.nwait = s.nwait - 5'd1;
        s.marks[next] = 1'b0;
        s.owner = next;
        s.depth = 8'd1;
        r.woken_valid = 1'b1;
        r.woken_thread = next;
        r.status = rmfw_pkg::ST_HANDED;
      end else begin
        s.held = 1'b0;
        s.owner = '0;
        s.depth = '0;
        r.status = rmfw_pkg::ST_FREED;
      end
    end
    r.lock_held = s.held;
    r.hold_count = s.held ? s.depth : 8'd0;
    return r;
  endfunction

  // Queue a request and track where it leaves the lock, to steer later ones
  task automatic queue_request(input rmfw_pkg::mode_t m, input logic [ID_W-1:0] tid);
    request_t q;
    q.mode = m;
    q.tid = tid;
    void'(apply_request(plan, m, tid));
    requests.push_back(q);
  endtask

  task automatic check_field(input string name, input int exp_val, input int got_val);
    if (exp_val != got_val) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
               got_val);
    end
  endtask

  // Driver: present a new beat at the falling edge once the last one was taken
  always @(negedge clk) begin
    logic gap;
    gap = !(issued >= 400 && issued < 700) && ($urandom_range(99) < 27);
    if (rst) begin
      start <= 1'b0;
    end else if (!start || beat_taken) begin
      if (requests.size() != 0 && !gap) begin
        start <= 1'b1;
        mode <= requests[0].mode;
        thread_id <= requests[0].tid;
        void'(requests.pop_front());
        issued++;
      end else begin
        // drop start and scramble the idle payload
        start <= 1'b0;
        mode <= 1'($urandom_range(1));
        thread_id <= ID_W'($urandom);
      end
    end
  end

  // Monitor: check each result beat, then predict for any beat taken this edge
  always @(posedge clk) begin
    if (rst) begin
      beat_taken = 1'b0;
    end else begin
      if (done) begin
        if (results_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat, expected none, actual status %0d",
                   $time, status);
        end else begin
          want = results_due.pop_front();
          check_field("status", want.status, status);
          check_field("woken_valid", want.woken_valid, woken_valid);
          check_field("woken_thread", want.woken_thread, woken_thread);
          check_field("lock_held", want.lock_held, lock_held);
          check_field("hold_count", want.hold_count, hold_count);
        end
      end
      beat_taken = start && !busy;
      if (beat_taken)
        results_due.push_back(apply_request(lock_now, rmfw_pkg::mode_t'(mode),
                                            thread_id));
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("recursive_mutex_fifo_waiters verification failed");
      $finish;
    end
  end

  initial begin
    logic [ID_W-1:0] crowd[CROWD_SIZE];
    logic [ID_W-1:0] tid;
    int              r;
    bit              drain;
    plan = '0;
    lock_now = '0;

    // Directed: misuse on a free lock, recursion, duplicate and full queue,
    // then lowering and two hand-overs
    queue_request(rmfw_pkg::MODE_RELEASE, 8'd0);
    queue_request(rmfw_pkg::MODE_ACQUIRE, 8'd0);
    queue_request(rmfw_pkg::MODE_ACQUIRE, 8'd0);
    queue_request(rmfw_pkg::MODE_RELEASE, 8'd255);
    queue_request(rmfw_pkg::MODE_ACQUIRE, 8'd255);
    queue_request(rmfw_pkg::MODE_ACQUIRE, 8'd255);
    for (int k = 1; k < MAX_WAITERS; k++)
      queue_request(rmfw_pkg::MODE_ACQUIRE, ID_W'(k * 16 + 1));
    queue_request(rmfw_pkg::MODE_ACQUIRE, 8'hAA);
    queue_request(rmfw_pkg::MODE_RELEASE, 8'd0);
    queue_request(rmfw_pkg::MODE_RELEASE, 8'd0);
    queue_request(rmfw_pkg::MODE_RELEASE, 8'd255);

    // Random: mostly holder traffic and contention from a small crowd
    foreach (crowd[k])
      crowd[k] = ID_W'($urandom);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 500) begin
        // run one holder up to the recursion limit and back down
        tid = plan.held ? plan.owner : crowd[0];
        repeat (MAX_RECURSION + 5) queue_request(rmfw_pkg::MODE_ACQUIRE, tid);
        repeat (MAX_RECURSION + 3) queue_request(rmfw_pkg::MODE_RELEASE, tid);
      end
      drain = ((i / 150) % 2) == 1;
      r = $urandom_range(99);
      tid = crowd[$urandom_range(CROWD_SIZE - 1)];
      if (plan.held && r < (drain ? 50 : 25))
        queue_request(rmfw_pkg::MODE_RELEASE, plan.owner);
      else if (plan.held && r < (drain ? 60 : 40))
        queue_request(rmfw_pkg::MODE_ACQUIRE, plan.owner);
      else if (r < 80)
        queue_request(rmfw_pkg::MODE_ACQUIRE, tid);
      else if (r < 90)
        queue_request(rmfw_pkg::MODE_RELEASE, tid);
      else
        queue_request(rmfw_pkg::mode_t'($urandom_range(1)), ID_W'($urandom));
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Hold until every beat is issued and every result has come back
    while (requests.size() != 0 || start || results_due.size() != 0)
      @(negedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0 && results_due.size() == 0)
      $display("recursive_mutex_fifo_waiters verification clean");
    else
      $display("recursive_mutex_fifo_waiters verification failed");
    $finish;
  end

endmodule
